@@ sv/u8cp_pkg.sv @@
package u8cp_pkg;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [20:0] MAX_CP         = 21'h10FFFF;
    localparam logic [20:0] SURR_LO        = 21'h00D800;
    localparam logic [20:0] SURR_HI        = 21'h00DFFF;
    localparam logic [20:0] MIN_CP2        = 21'h000080;
    localparam logic [20:0] MIN_CP3        = 21'h000800;
    localparam logic [20:0] MIN_CP4        = 21'h010000;

    localparam logic [7:0] MASK2 = 8'hE0;
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] MASK3 = 8'hF0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] MASK4 = 8'hF8;
    localparam logic [7:0] LEAD4 = 8'hF0;

    // result of one scan step at the head of the byte window
    typedef struct packed {
        logic        emit;
        logic [20:0] cp;
        logic [2:0]  adv;
        logic        done;
    } step_t;

    // sequence length announced by a start byte, 0 for a bad start byte
    function automatic logic [2:0] start_len(input logic [7:0] b);
        logic [2:0] len;
        if (!b[7])
        begin
            len = 3'd1;
        end
        else if ((b & MASK2) == LEAD2)
        begin
            len = 3'd2;
        end
        else if ((b & MASK3) == LEAD3)
        begin
            len = 3'd3;
        end
        else if ((b & MASK4) == LEAD4)
        begin
            len = 3'd4;
        end
        else
        begin
            len = 3'd0;
        end
        return len;
    endfunction

endpackage

@@ sv/u8cp_step_unit.sv @@
module u8cp_step_unit (
    input  logic [3:0][7:0]     win,
    input  logic [2:0]          rem,
    input  logic                last,
    output u8cp_pkg::step_t     res
);
    import u8cp_pkg::*;

    logic [2:0]  len;
    logic [20:0] cp2;
    logic [20:0] cp3;
    logic [20:0] cp4;
    logic [20:0] value;
    logic        cont_bad;
    logic        invalid;
    logic [2:0]  rem_left;
    logic [2:0]  look_len;
    logic        step_emit;
    logic [20:0] step_cp;
    logic [2:0]  step_adv;
    logic        step_done;

    assign len = start_len(win[0]);
    assign cp2 = {10'd0, win[0][4:0], win[1][5:0]};
    assign cp3 = {5'd0, win[0][3:0], win[1][5:0], win[2][5:0]};
    assign cp4 = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};

    // continuation bytes must be 10xxxxxx
    assign cont_bad = ((len >= 3'd2) && (win[1][7:6] != 2'b10))
                   || ((len >= 3'd3) && (win[2][7:6] != 2'b10))
                   || ((len == 3'd4) && (win[3][7:6] != 2'b10));

    always_comb
    begin
        unique case (len)
            3'd1:    value = {13'd0, win[0]};
            3'd2:    value = cp2;
            3'd3:    value = cp3;
            3'd4:    value = cp4;
            default: value = REPLACEMENT_CP;
        endcase
    end

    // out of range, surrogate or overlong
    assign invalid = (value > MAX_CP)
                  || ((value >= SURR_LO) && (value <= SURR_HI))
                  || ((len == 3'd2) && (value < MIN_CP2))
                  || ((len == 3'd3) && (value < MIN_CP3))
                  || ((len == 3'd4) && (value < MIN_CP4));

    always_comb
    begin
        step_emit = 1'b1;
        step_cp   = REPLACEMENT_CP;
        step_adv  = 3'd1;
        priority if (len == 3'd0)
        begin
            step_adv = 3'd1;
        end
        else if (len > rem)
        begin
            // sequence still short: flush at stream end, otherwise hold
            step_emit = last;
            step_adv  = last ? rem : 3'd0;
        end
        else if (cont_bad)
        begin
            step_adv = 3'd1;
        end
        else
        begin
            step_cp  = invalid ? REPLACEMENT_CP : value;
            step_adv = len;
        end
    end

    // look ahead at the next start byte so the last result carries run_end
    assign rem_left  = rem - step_adv;
    assign look_len  = start_len(win[step_adv[1:0]]);
    assign step_done = !step_emit || (rem_left == 3'd0)
                    || (!last && (look_len != 3'd0) && (look_len > rem_left));

    assign res = {step_emit, step_cp, step_adv, step_done};

endmodule

@@ sv/utf8_to_codepoint_decoder.sv @@
// flow: a byte accepted in IDLE is registered into the byte window, and SCAN registers its code points
//   in the output register; no new byte is taken until SCAN returns to IDLE;
//   the step unit decodes one sequence per cycle, and a full output register stalls it
// reset: rst_n clears the held byte count, the sequencer and the output valid at once;
//   held bytes are not cleared and no clearing pass runs
module utf8_to_codepoint_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tlast,   // stream_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // code_point [20:0], zero pad [23:21]
    output logic        m_axis_tlast,   // stream_end
    output logic        m_axis_tuser    // run_end
);
    import u8cp_pkg::*;

    typedef enum logic {
        IDLE,
        SCAN
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      held_count_reg, held_count_next;
    logic [2:0]      rem_reg, rem_next;
    logic            last_reg, last_next;
    logic [3:0][7:0] win_reg, win_next;
    logic            out_valid_reg, out_valid_next;
    logic [20:0]     out_cp_reg, out_cp_next;
    logic            out_run_reg, out_run_next;
    logic            out_stream_reg, out_stream_next;

    step_t           step;
    logic            in_xfer;
    logic            advance;

    // one decode step at the head of the byte window, reused every scan cycle
    u8cp_step_unit u_step (
        .win  (win_reg),
        .rem  (rem_reg),
        .last (last_reg),
        .res  (step)
    );

    assign s_axis_tready = (state_reg == IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    // a step may run when the output slot is free or being emptied this cycle
    assign advance       = (state_reg == SCAN) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next      = state_reg;
        held_count_next = held_count_reg;
        rem_next        = rem_reg;
        last_next       = last_reg;
        win_next        = win_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_cp_next     = out_cp_reg;
        out_run_next    = out_run_reg;
        out_stream_next = out_stream_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (in_xfer)
                begin
                    // new byte lands behind the held bytes
                    win_next[held_count_reg] = s_axis_tdata;
                    rem_next                 = {1'b0, held_count_reg} + 3'd1;
                    last_next                = s_axis_tlast;
                    state_next               = SCAN;
                end
            end
            SCAN:
            begin
                if (advance)
                begin
                    if (step.emit)
                    begin
                        out_valid_next  = 1'b1;
                        out_cp_next     = step.cp;
                        out_run_next    = step.done;
                        out_stream_next = step.done && last_reg;
                    end
                    // consume bytes by shifting the window toward entry 0
                    win_next = win_reg >> {step.adv, 3'b000};
                    rem_next = rem_reg - step.adv;
                    if (step.done)
                    begin
                        // what is left is an incomplete sequence, kept unless the stream ended
                        held_count_next = last_reg ? 2'd0 : rem_next[1:0];
                        state_next      = IDLE;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            held_count_reg <= 2'd0;
            rem_reg        <= 3'd0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_cp_reg     <= 21'd0;
            out_run_reg    <= 1'b0;
            out_stream_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            rem_reg        <= rem_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
            out_cp_reg     <= out_cp_next;
            out_run_reg    <= out_run_next;
            out_stream_reg <= out_stream_next;
        end
    end

    // byte window is payload only
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_cp_reg};
    assign m_axis_tlast  = out_stream_reg;
    assign m_axis_tuser  = out_run_reg;

endmodule

@@ test/utf8_to_codepoint_decoder_test.sv @@
`timescale 1ns / 100ps

// byte-level testbench for the utf-8 to code point decoder
module utf8_to_codepoint_decoder_test;

    import u8cp_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_BYTES  = 270;
    localparam int SETTLE_CYCLES = 32;
    localparam int LIMIT_CYCLES  = 200000;

    // one byte waiting to go out, or a marker that holds the sender until the output drains
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       drain;
    } byte_item_t;

    // one code point the decoder owes us
    typedef struct packed {
        logic [20:0] code_point;
        logic        run_end;
        logic        stream_end;
    } code_point_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // in_byte
    logic        s_axis_tlast  = 1'b0;    // stream_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // code_point [20:0], zero pad [23:21]
    logic        m_axis_tlast;            // stream_end
    logic        m_axis_tuser;            // run_end

    byte_item_t  bytes_to_send[$];
    code_point_t code_points_due[$];
    logic [7:0]  partial_seq[$];          // bytes of an incomplete sequence, oldest first

    int          error_count = 0;
    int          cycle_count = 0;
    int          random_bytes = 0;

    // sender burst control
    int          burst_left = 0;
    int          gap_left = 0;
    byte_item_t  send_item;
    logic        send_valid;

    // receiver stall control
    logic [15:0] stall_pattern;
    int          stall_pos;
    code_point_t got_want;

    utf8_to_codepoint_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // decode one accepted byte against the held partial sequence and
    // queue every code point it releases
    // ------------------------------------------------------------------
    task automatic decode_utf8_byte(input logic [7:0] in_byte, input logic stream_last);
        logic [7:0]  win[$];
        code_point_t found[$];
        code_point_t res;
        logic [7:0]  c;
        logic [20:0] cp;
        logic        bad;
        logic        stop;
        int          n;
        int          pos;
        int          len;
        win = partial_seq;
        win.insert(win.size(), in_byte);
        n = win.size();
        pos = 0;
        stop = 1'b0;
        res = '0;
        while (pos < n && !stop)
        begin
            c = win[pos];
            cp = '0;
            if (!c[7])
            begin
                len = 1;
                cp = {14'd0, c[6:0]};
            end
            else if ((c & MASK2) == LEAD2)
            begin
                len = 2;
                cp = {16'd0, c[4:0]};
            end
            else if ((c & MASK3) == LEAD3)
            begin
                len = 3;
                cp = {17'd0, c[3:0]};
            end
            else if ((c & MASK4) == LEAD4)
            begin
                len = 4;
                cp = {18'd0, c[2:0]};
            end
            else
            begin
                len = 0;
            end

            if (len == 0)
            begin
                // bad start byte, consume it alone
                res.code_point = REPLACEMENT_CP;
                found.insert(found.size(), res);
                pos++;
            end
            else if (len > n - pos)
            begin
                // sequence still short: keep waiting, or give up at stream end
                if (stream_last)
                begin
                    res.code_point = REPLACEMENT_CP;
                    found.insert(found.size(), res);
                    pos = n;
                end
                stop = 1'b1;
            end
            else
            begin
                bad = 1'b0;
                for (int j = 1; j < len; j++)
                begin
                    if (!bad)
                    begin
                        if (win[pos + j][7:6] != 2'b10)
                            bad = 1'b1;
                        else
                            cp = {cp[14:0], win[pos + j][5:0]};
                    end
                end
                if (bad)
                begin
                    // replace the start byte only, rescan from the next one
                    res.code_point = REPLACEMENT_CP;
                    pos++;
                end
                else
                begin
                    if (cp > MAX_CP || (cp >= SURR_LO && cp <= SURR_HI) ||
                        (len == 2 && cp < MIN_CP2) ||
                        (len == 3 && cp < MIN_CP3) ||
                        (len == 4 && cp < MIN_CP4))
                        res.code_point = REPLACEMENT_CP;
                    else
                        res.code_point = cp;
                    pos += len;
                end
                found.insert(found.size(), res);
            end
        end

        partial_seq.delete();
        if (!stream_last)
        begin
            for (int k = pos; k < n; k++)
                partial_seq.insert(partial_seq.size(), win[k]);
        end

        if (found.size() > 0)
        begin
            found[found.size() - 1].run_end = 1'b1;
            found[found.size() - 1].stream_end = stream_last;
        end
        foreach (found[k])
            code_points_due.insert(code_points_due.size(), found[k]);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b, input logic last);
        byte_item_t item;
        item.data = b;
        item.last = last;
        item.drain = 1'b0;
        bytes_to_send.insert(bytes_to_send.size(), item);
    endtask

    task automatic add_drain();
        byte_item_t item;
        item.data = 8'h00;
        item.last = 1'b0;
        item.drain = 1'b1;
        bytes_to_send.insert(bytes_to_send.size(), item);
    endtask

    // encoded bytes of cp at the given length, first byte in the top bits
    function automatic logic [31:0] utf8_bytes(input logic [20:0] cp, input int len);
        case (len)
            1: return {1'b0, cp[6:0], 24'h0};
            2: return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
            3: return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
            default: return {5'b11110, cp[20:18], 2'b10, cp[17:12],
                             2'b10, cp[11:6], 2'b10, cp[5:0]};
        endcase
    endfunction

    // one random piece of a stream; ends is set when it closes the stream
    task automatic add_token(output logic ends);
        int          kind;
        int          len;
        int          keep;
        logic [20:0] cp;
        logic [31:0] word;
        ends = 1'b0;
        kind = $urandom_range(0, 19);
        len = $urandom_range(1, 4);
        keep = len;
        if (kind >= 15 && kind != 17 && kind != 18)
        begin
            // broken or truncated sequences need at least two bytes
            len = $urandom_range(2, 4);
            keep = $urandom_range(1, len - 1);
        end
        case (len)
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3: cp = 21'($urandom_range('h800, 'hFFFF));
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        // raw payload: overlong, surrogate and out-of-range forms show up here
        if (kind >= 12 && kind <= 14)
            cp = 21'($urandom());
        word = utf8_bytes(cp, len);

        if (kind == 17 || kind == 18)
        begin
            // plain noise byte
            add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            for (int k = 0; k < keep; k++)
                add_byte(word[31 - 8 * k -: 8], 1'b0);
            if (kind == 15 || kind == 16)
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            if (kind == 19)
                ends = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of random length, random gaps, drain markers
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                decode_utf8_byte(s_axis_tdata, s_axis_tlast);

            if (!s_axis_tvalid || s_axis_tready)
            begin
                send_valid = 1'b0;
                if (bytes_to_send.size() > 0 && bytes_to_send[0].drain)
                begin
                    // hold off until every owed code point has come out
                    if (code_points_due.size() == 0)
                        void'(bytes_to_send.pop_front());
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (bytes_to_send.size() > 0)
                begin
                    if (burst_left == 0)
                        burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 16);
                    send_item = bytes_to_send.pop_front();
                    s_axis_tdata <= send_item.data;
                    s_axis_tlast <= send_item.last;
                    send_valid = 1'b1;
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                s_axis_tvalid <= send_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: ready follows a rotating stall pattern, checks each transaction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_pattern = 16'hFFFF;
            stall_pos = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (code_points_due.size() == 0)
                begin
                    $error("unexpected code point transaction, code_point %h",
                           m_axis_tdata[20:0]);
                    error_count++;
                end
                else
                begin
                    got_want = code_points_due.pop_front();
                    if (m_axis_tdata[20:0] !== got_want.code_point)
                    begin
                        $error("code_point: expected %h, actual %h",
                               got_want.code_point, m_axis_tdata[20:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[23:21] !== 3'b000)
                    begin
                        $error("tdata pad: expected %h, actual %h",
                               3'b000, m_axis_tdata[23:21]);
                        error_count++;
                    end
                    if (m_axis_tuser !== got_want.run_end)
                    begin
                        $error("run_end: expected %b, actual %b",
                               got_want.run_end, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tlast !== got_want.stream_end)
                    begin
                        $error("stream_end: expected %b, actual %b",
                               got_want.stream_end, m_axis_tlast);
                        error_count++;
                    end
                end
            end

            // new pattern each time the pattern position wraps: free running, random, or mostly stalled
            stall_pos++;
            if (stall_pos == 16)
            begin
                stall_pos = 0;
                case ($urandom_range(0, 3))
                    0: stall_pattern = 16'hFFFF;
                    1: stall_pattern = 16'($urandom()) & 16'($urandom()) | 16'h8000;
                    default: stall_pattern = 16'($urandom()) | 16'h0001;
                endcase
            end
            m_axis_tready <= stall_pattern[stall_pos];
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("utf8_to_codepoint_decoder_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic ends;
        int   tokens;
        logic paused;

        paused = 1'b0;
        // single-byte stream, nul
        add_byte(8'h00, 1'b1);
        // largest two-, three- and four-byte forms
        add_byte(8'hDF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hEF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hF4, 1'b0);
        add_byte(8'h8F, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        // just above the code space
        add_byte(8'hF4, 1'b0);
        add_byte(8'h90, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b0);
        // surrogate
        add_byte(8'hED, 1'b0);
        add_byte(8'hA0, 1'b0);
        add_byte(8'h80, 1'b0);
        // overlong two-byte nul
        add_byte(8'hC0, 1'b0);
        add_byte(8'h80, 1'b0);
        // bad start bytes
        add_byte(8'h80, 1'b0);
        add_byte(8'hFF, 1'b0);
        // bad continuation forces a rescan, then truncation at stream end
        add_byte(8'hE2, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'h9F, 1'b1);
        add_drain();

        // random streams, mostly well-formed with random content
        while (random_bytes < RANDOM_BYTES)
        begin
            tokens = $urandom_range(1, 10);
            ends = 1'b0;
            for (int t = 0; t < tokens && !ends; t++)
            begin
                random_bytes -= bytes_to_send.size();
                add_token(ends);
                random_bytes += bytes_to_send.size();
            end
            bytes_to_send[bytes_to_send.size() - 1].last = 1'b1;
            // one mid-run pause until the output side is empty
            if (!paused && random_bytes >= RANDOM_BYTES / 2)
            begin
                add_drain();
                paused = 1'b1;
            end
        end

        while (!rst_n)
            @(posedge clk);
        while (bytes_to_send.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (code_points_due.size() > 0)
            @(posedge clk);
        // let any stray transaction show up
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("utf8_to_codepoint_decoder_test: PASS");
        else
            $display("utf8_to_codepoint_decoder_test: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/u8cp_pkg.sv
sv/u8cp_step_unit.sv
sv/utf8_to_codepoint_decoder.sv
test/utf8_to_codepoint_decoder_test.sv
